// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ESCP_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("escp: assertion failed");

// next-cycle implication
`define ESCP_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("escp: assertion failed");

`endif

// ===== rtl/escp_pkg.sv =====
// ----------------------------------------------------------------------------
// escp_pkg
// Sizes, controller states and the command/status bundles of the pager.
// ----------------------------------------------------------------------------
package escp_pkg;

	localparam int PAGES       = 64;
	localparam int FRAMES      = 16;
	localparam int PAGE_W      = $clog2(PAGES);
	localparam int FRAME_W     = $clog2(FRAMES);
	localparam int FC_W        = 5;
	localparam logic [FC_W-1:0] FC_RESET = 5'd16;
	localparam int CHUNK       = 8;
	localparam int CHUNKS      = PAGES / CHUNK;
	localparam int CHUNK_W     = $clog2(CHUNKS);
	localparam int CHUNK_IW    = $clog2(CHUNK);
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SCAN,
		ST_SLOT,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic take;
		logic look;
		logic scan;
		logic slot;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic free_ok;
		logic found;
		logic slot_done;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/escp_ram.sv =====
// ----------------------------------------------------------------------------
// escp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module escp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/escp_ctrl.sv =====
// ----------------------------------------------------------------------------
// escp_ctrl
// Sequencer: lookup, clock scan, disk slot search and commit of one access.
// ----------------------------------------------------------------------------
module escp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  escp_pkg::sts_t  sts,
	output escp_pkg::cmd_t  cmd
);

	escp_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= escp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			escp_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = escp_pkg::ST_LOOK;
			end
			escp_pkg::ST_LOOK: begin
				if (sts.hit || sts.free_ok) state_d = escp_pkg::ST_COMMIT;
				else state_d = escp_pkg::ST_SCAN;
			end
			escp_pkg::ST_SCAN: begin
				if (sts.found) state_d = escp_pkg::ST_SLOT;
			end
			escp_pkg::ST_SLOT: begin
				if (sts.slot_done) state_d = escp_pkg::ST_COMMIT;
			end
			escp_pkg::ST_COMMIT: begin
				if (sts.out_free) state_d = escp_pkg::ST_IDLE;
			end
			default: state_d = escp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready   = (state_q == escp_pkg::ST_IDLE);
		cmd.take   = (state_q == escp_pkg::ST_IDLE) && s_tvalid;
		cmd.look   = (state_q == escp_pkg::ST_LOOK);
		cmd.scan   = (state_q == escp_pkg::ST_SCAN);
		cmd.slot   = (state_q == escp_pkg::ST_SLOT);
		cmd.commit = (state_q == escp_pkg::ST_COMMIT) && sts.out_free;
	end

endmodule

// ===== rtl/escp_dp.sv =====
// ----------------------------------------------------------------------------
// escp_dp
// Frame table, clock hand, disk slot map and result word register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module escp_dp (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [escp_pkg::IN_TDATA_W-1:0]    s_tdata,
	input  logic                               s_tuser,
	input  logic                               cfg_we,
	input  logic [escp_pkg::FC_W-1:0]          cfg_wdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	output logic [escp_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  escp_pkg::cmd_t                     cmd,
	output escp_pkg::sts_t                     sts
);

	localparam int PW  = escp_pkg::PAGE_W;
	localparam int FW  = escp_pkg::FRAME_W;
	localparam int NF  = escp_pkg::FRAMES;
	localparam int NP  = escp_pkg::PAGES;
	localparam int CW  = escp_pkg::FC_W;

	logic [CW-1:0]   fc_q;
	logic [PW-1:0]   pg_q;
	logic            wr_q;

	logic [NF-1:0]   fv_q;
	logic [PW-1:0]   fpage_q [NF];
	logic [NF-1:0]   fref_q;
	logic [NF-1:0]   fdirty_q;

	logic [FW-1:0]   hand_q;
	logic [FW-1:0]   cnt_q;
	logic            phase_q;

	logic            hit_q, free_ok_q, src_ok_q;
	logic [FW-1:0]   hidx_q, fidx_q;
	logic [PW-1:0]   src_q;

	logic [escp_pkg::CHUNK_W-1:0] chunk_q;
	logic            dst_ok_q;
	logic [PW-1:0]   dst_q;

	logic [NP-1:0]   on_disk_q;
	logic [NP-1:0]   used_q;

	logic [CW-1:0]   n;
	logic [FW-1:0]   n_m1;
	logic [NF-1:0]   match;
	logic            hit;
	logic [FW-1:0]   hidx;
	logic            free_ok;
	logic [FW-1:0]   fidx;
	logic            found;
	logic [PW-1:0]   chunk_base;
	logic [escp_pkg::CHUNK-1:0] chunk_free;
	logic            chunk_any;
	logic [escp_pkg::CHUNK_IW-1:0] chunk_low;
	logic [PW-1:0]   vpg;
	logic [FW-1:0]   hand_next;
	logic [FW-1:0]   f_load;
	logic            miss_commit, evict;
	logic            scan_start;
	logic            hand_ok;
	logic            out_free;
	logic [PW-1:0]   ram_rdata;
	logic            r_hv, r_hdo, r_hdi;
	logic [FW-1:0]   r_frame;

	always_comb begin
		if (fc_q == '0) n = CW'(1);
		else if (fc_q > CW'(NF)) n = CW'(NF);
		else n = fc_q;
	end
	assign n_m1 = FW'(n - CW'(1));

	always_comb begin
		hidx    = '0;
		fidx    = '0;
		free_ok = 1'b0;
		for (int i = 0; i < NF; i++) begin
			match[i] = fv_q[i] && (fpage_q[i] == pg_q);
		end
		for (int i = NF - 1; i >= 0; i--) begin
			if (match[i]) hidx = FW'(i);
		end
		for (int i = NF - 1; i >= 0; i--) begin
			if (!fv_q[i] && (CW'(i) < n)) begin
				fidx    = FW'(i);
				free_ok = 1'b1;
			end
		end
	end
	assign hit = |match;

	assign found = !fref_q[hand_q] && (phase_q ? fdirty_q[hand_q] : !fdirty_q[hand_q]);
	assign hand_next = (hand_q == n_m1) ? '0 : hand_q + FW'(1);
	assign hand_ok = ({1'b0, hand_q} < n);
	assign scan_start = cmd.look && !hit && !free_ok;

	assign chunk_base = {chunk_q, escp_pkg::CHUNK_IW'(0)};
	assign chunk_free = ~used_q[chunk_base +: escp_pkg::CHUNK];
	assign chunk_any  = |chunk_free;
	always_comb begin
		chunk_low = '0;
		for (int i = escp_pkg::CHUNK - 1; i >= 0; i--) begin
			if (chunk_free[i]) chunk_low = escp_pkg::CHUNK_IW'(i);
		end
	end

	assign vpg         = fpage_q[hand_q];
	assign evict       = !free_ok_q;
	assign f_load      = free_ok_q ? fidx_q : hand_q;
	assign miss_commit = cmd.commit && !hit_q;
	assign out_free    = !m_tvalid || m_tready;

	assign sts.hit       = hit;
	assign sts.free_ok   = free_ok;
	assign sts.found     = found;
	assign sts.slot_done = chunk_any || (chunk_q == escp_pkg::CHUNK_W'(escp_pkg::CHUNKS - 1));
	assign sts.out_free  = out_free;

	escp_ram #(
		.WIDTH(PW),
		.DEPTH(NP)
	) u_slot_ram (
		.clk  (clk),
		.we   (miss_commit && evict && dst_ok_q),
		.waddr(vpg),
		.wdata(dst_q),
		.re   (cmd.take),
		.raddr(s_tdata[PW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fc_q      <= escp_pkg::FC_RESET;
			fv_q      <= '0;
			hand_q    <= '0;
			cnt_q     <= '0;
			phase_q   <= 1'b0;
			chunk_q   <= '0;
			dst_ok_q  <= 1'b0;
			on_disk_q <= '0;
			used_q    <= '0;
			m_tvalid  <= 1'b0;
		end else begin
			if (cfg_we) fc_q <= cfg_wdata;

			if (cmd.look) begin
				cnt_q    <= '0;
				phase_q  <= 1'b0;
				chunk_q  <= '0;
				dst_ok_q <= 1'b0;
			end
			if (scan_start) begin
				hand_q <= hand_ok ? hand_q : '0;
			end
			if (cmd.scan && !found) begin
				hand_q <= hand_next;
				if (cnt_q == n_m1) begin
					cnt_q   <= '0;
					phase_q <= !phase_q;
				end else begin
					cnt_q <= cnt_q + FW'(1);
				end
			end
			if (cmd.slot && !chunk_any) chunk_q <= chunk_q + escp_pkg::CHUNK_W'(1);
			if (cmd.slot && chunk_any) dst_ok_q <= 1'b1;

			if (miss_commit) begin
				fv_q[f_load]    <= 1'b1;
				on_disk_q[pg_q] <= 1'b0;
				if (evict) begin
					on_disk_q[vpg] <= dst_ok_q;
					hand_q         <= hand_next;
					if (dst_ok_q) used_q[dst_q] <= 1'b1;
				end
				if (src_ok_q) used_q[src_q] <= 1'b0;
			end

			if (cmd.commit) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			pg_q <= s_tdata[PW-1:0];
			wr_q <= s_tuser;
		end
		if (cmd.look) begin
			hit_q     <= hit;
			hidx_q    <= hidx;
			free_ok_q <= free_ok;
			fidx_q    <= fidx;
			src_ok_q  <= on_disk_q[pg_q];
			src_q     <= ram_rdata;
		end
		if (cmd.slot && chunk_any) dst_q <= chunk_base | PW'(chunk_low);
		if (cmd.scan && !found && phase_q) fref_q[hand_q] <= 1'b0;
		if (cmd.commit) begin
			if (hit_q) begin
				fref_q[hidx_q] <= 1'b1;
				if (wr_q) fdirty_q[hidx_q] <= 1'b1;
			end else begin
				fpage_q[f_load]  <= pg_q;
				fref_q[f_load]   <= 1'b1;
				fdirty_q[f_load] <= wr_q;
			end
		end
	end

	assign r_hv    = !hit_q && evict;
	assign r_hdo   = r_hv && dst_ok_q;
	assign r_hdi   = !hit_q && src_ok_q;
	assign r_frame = hit_q ? hidx_q : f_load;

	// word: hit, frame, has_victim, victim_page, has_disk_out, disk_out_slot,
	// has_disk_in, disk_in_slot, zero pad
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			m_tdata <= {6'b0,
				r_hdi ? src_q : PW'(0), r_hdi,
				r_hdo ? dst_q : PW'(0), r_hdo,
				r_hv ? vpg : PW'(0), r_hv,
				r_frame, hit_q};
		end
	end

	`ESCP_ASSERT_IMP(a_hand_active, cmd.scan, hand_ok)
	`ESCP_ASSERT_IMP(a_page_once, 1'b1, $countones(match) <= 1)
	`ESCP_ASSERT_NXT(a_slot_free, cmd.slot && chunk_any, dst_ok_q && !used_q[dst_q])
	`ESCP_ASSERT_IMP(a_word_from_commit, $rose(m_tvalid), $past(cmd.commit))

endmodule

// ===== rtl/enhanced_second_chance_pager.sv =====
// A hit, or a miss with a free frame, passes from the accepting edge through the
// lookup and commit states; the commit waits for the output register to be free,
// and m_tvalid is registered from it. A miss with no free frame adds the clock
// scan, one frame per cycle, then the disk slot search, 8 slots per cycle. One
// access at a time; the next is taken once the word is committed to the output
// register. Reset (arst_n low): frames and slots empty, hand 0, frame_count 16.
// ----------------------------------------------------------------------------
// enhanced_second_chance_pager
// Page access handler with enhanced second-chance (clock) victim selection.
// ----------------------------------------------------------------------------
module enhanced_second_chance_pager (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [escp_pkg::IN_TDATA_W-1:0]   s_tdata,   // page, pad
	input  logic                              s_tuser,   // is_write
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// hit, frame, has_victim, victim_page, has_disk_out, disk_out_slot,
	// has_disk_in, disk_in_slot, pad
	output logic [escp_pkg::OUT_TDATA_W-1:0]  m_tdata,
	input  logic                              cfg_we,
	input  logic [escp_pkg::FC_W-1:0]         cfg_wdata
);

	escp_pkg::cmd_t cmd;
	escp_pkg::sts_t sts;

	escp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	escp_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

// ===== dv/enhanced_second_chance_pager_test.sv =====
// ----------------------------------------------------------------------------
// enhanced_second_chance_pager_test
// Self-checking bench for the pager: page accesses are streamed in, and every
// output word is compared with a local model of frames, disk slots, reference
// and dirty bits and the clock hand, across several frame_count settings.
// ----------------------------------------------------------------------------
module enhanced_second_chance_pager_test;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [5:0] page;
		logic       wr;
	} access_t;

	// laid out as m_tdata[25:0], hit in bit 0
	typedef struct packed {
		logic [5:0] disk_in_slot;
		logic       has_disk_in;
		logic [5:0] disk_out_slot;
		logic       has_disk_out;
		logic [5:0] victim_page;
		logic       has_victim;
		logic [3:0] frame;
		logic       hit;
	} pager_word_t;

	logic                             clk;
	logic                             arst_n;
	logic                             s_tvalid;
	logic                             s_tready;
	logic [escp_pkg::IN_TDATA_W-1:0]  s_tdata;
	logic                             s_tuser;
	logic                             m_tvalid;
	logic                             m_tready;
	logic [escp_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                             cfg_we;
	logic [escp_pkg::FC_W-1:0]        cfg_wdata;

	access_t     pending_accesses[$];
	pager_word_t expected_words[$];
	access_t     next_access;
	pager_word_t got_word;
	pager_word_t want_word;
	logic        in_taken;
	bit          calm;
	int          errors;
	int          words_checked;
	int          hits_seen;
	int          evictions_seen;
	int          disk_ins_seen;
	int          settings_used;

	// pager state as the model keeps it
	logic [escp_pkg::FC_W-1:0] fc_m;
	bit              frame_valid_m[escp_pkg::FRAMES];
	logic [5:0]      frame_page_m[escp_pkg::FRAMES];
	bit              slot_valid_m[escp_pkg::PAGES];
	logic [5:0]      slot_page_m[escp_pkg::PAGES];
	bit              seen_m[escp_pkg::PAGES];
	bit              on_disk_m[escp_pkg::PAGES];
	bit              ref_m[escp_pkg::PAGES];
	bit              dirty_m[escp_pkg::PAGES];
	int              hand_m;

	enhanced_second_chance_pager i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	initial begin
		#4_000_000;
		$display("enhanced_second_chance_pager_test: done, errors");
		$finish;
	end

	function automatic int eff_frames(input logic [escp_pkg::FC_W-1:0] v);
		if (v == 0) return 1;
		if (v > escp_pkg::FRAMES) return escp_pkg::FRAMES;
		return int'(v);
	endfunction

	function automatic pager_word_t page_access(input logic [5:0] pg, input bit wr);
		pager_word_t r;
		int n, f, src, vf, dst, i, rnd, k;
		logic [5:0] p, vpg;
		bit found;
		r = '0;
		n = eff_frames(fc_m);
		f = -1;
		for (i = 0; i < escp_pkg::FRAMES; i++)
			if (f < 0 && frame_valid_m[i] && frame_page_m[i] == pg) f = i;
		if (f >= 0) begin
			r.hit = 1'b1;
			r.frame = 4'(f);
			ref_m[pg] = 1'b1;
			if (wr) dirty_m[pg] = 1'b1;
			hits_seen++;
			return r;
		end
		src = -1;
		if (seen_m[pg] && on_disk_m[pg])
			for (i = 0; i < escp_pkg::PAGES; i++)
				if (src < 0 && slot_valid_m[i] && slot_page_m[i] == pg) src = i;
		for (i = 0; i < n; i++)
			if (f < 0 && !frame_valid_m[i]) f = i;
		if (f < 0) begin
			if (hand_m >= n) hand_m = 0;
			found = 1'b0;
			vf = 0;
			// clean-unreferenced sweep, then dirty-unreferenced sweep clearing refs
			for (rnd = 0; rnd < 2; rnd++) begin
				for (k = 0; k < n; k++)
					if (!found) begin
						p = frame_page_m[hand_m];
						if (!ref_m[p] && !dirty_m[p]) begin
							found = 1'b1;
							vf = hand_m;
						end else
							hand_m = (hand_m + 1) % n;
					end
				for (k = 0; k < n; k++)
					if (!found) begin
						p = frame_page_m[hand_m];
						if (!ref_m[p] && dirty_m[p]) begin
							found = 1'b1;
							vf = hand_m;
						end else begin
							ref_m[p] = 1'b0;
							hand_m = (hand_m + 1) % n;
						end
					end
			end
			vpg = frame_page_m[vf];
			dst = -1;
			for (i = 0; i < escp_pkg::PAGES; i++)
				if (dst < 0 && !slot_valid_m[i]) dst = i;
			r.has_victim = 1'b1;
			r.victim_page = vpg;
			if (dst >= 0) begin
				r.has_disk_out = 1'b1;
				r.disk_out_slot = 6'(dst);
				slot_valid_m[dst] = 1'b1;
				slot_page_m[dst] = vpg;
				on_disk_m[vpg] = 1'b1;
			end else begin
				seen_m[vpg] = 1'b0;
				on_disk_m[vpg] = 1'b0;
			end
			frame_valid_m[vf] = 1'b0;
			hand_m = (vf + 1) % n;
			f = vf;
			evictions_seen++;
		end
		if (src >= 0) begin
			r.has_disk_in = 1'b1;
			r.disk_in_slot = 6'(src);
			slot_valid_m[src] = 1'b0;
			slot_page_m[src] = '0;
			disk_ins_seen++;
		end
		on_disk_m[pg] = 1'b0;
		seen_m[pg] = 1'b1;
		frame_valid_m[f] = 1'b1;
		frame_page_m[f] = pg;
		ref_m[pg] = 1'b1;
		dirty_m[pg] = wr;
		r.frame = 4'(f);
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		in_taken <= s_tvalid && s_tready;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_words.push_back(page_access(s_tdata[5:0], s_tuser));
			if (m_tvalid && m_tready) begin
				got_word = pager_word_t'(m_tdata[25:0]);
				if (expected_words.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual %h", $time, m_tdata);
					errors++;
				end else begin
					want_word = expected_words.pop_front();
					words_checked++;
					check_field("hit", want_word.hit, got_word.hit);
					check_field("frame", want_word.frame, got_word.frame);
					check_field("has_victim", want_word.has_victim, got_word.has_victim);
					check_field("victim_page", want_word.victim_page, got_word.victim_page);
					check_field("has_disk_out", want_word.has_disk_out, got_word.has_disk_out);
					check_field("disk_out_slot", want_word.disk_out_slot,
						got_word.disk_out_slot);
					check_field("has_disk_in", want_word.has_disk_in, got_word.has_disk_in);
					check_field("disk_in_slot", want_word.disk_in_slot, got_word.disk_in_slot);
				end
			end
		end
	end

	// driver
	always @(negedge clk) begin
		if (!s_tvalid || in_taken) begin
			if (arst_n && pending_accesses.size() != 0 &&
					(calm || $urandom_range(99) >= 19)) begin
				next_access = pending_accesses.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {2'b00, next_access.page};
				s_tuser <= next_access.wr;
			end else
				s_tvalid <= 1'b0;
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (arst_n)
			m_tready <= calm || $urandom_range(99) >= 19;
	end

	task automatic push_access(input logic [5:0] pg, input bit wr);
		access_t a;
		a.page = pg;
		a.wr = wr;
		pending_accesses.push_back(a);
	endtask

	task automatic drain();
		while (pending_accesses.size() != 0 || s_tvalid || expected_words.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_frame_count(input logic [escp_pkg::FC_W-1:0] v);
		drain();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		fc_m = v;
		settings_used++;
	endtask

	// mostly a sliding working set a little wider than the frames, some noise
	task automatic queue_random(input int count);
		int i, n, win, base;
		logic [5:0] pg;
		n = eff_frames(fc_m);
		win = n + n / 2 + 1;
		base = $urandom_range(63);
		for (i = 0; i < count; i++) begin
			if ($urandom_range(99) < 5) base = $urandom_range(63);
			if ($urandom_range(99) < 20)
				pg = 6'($urandom_range(63));
			else
				pg = 6'((base + $urandom_range(win - 1)) % escp_pkg::PAGES);
			push_access(pg, $urandom_range(99) < 40);
		end
	endtask

	initial begin
		logic [escp_pkg::FC_W-1:0] fc_plan [10];
		int ph, i;
		fc_plan = '{5'd4, 5'd16, 5'd1, 5'd8, 5'd31, 5'd0, 5'd3, 5'd12, 5'd2, 5'd16};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_taken = 1'b0;
		calm = 1'b0;
		errors = 0;
		words_checked = 0;
		hits_seen = 0;
		evictions_seen = 0;
		disk_ins_seen = 0;
		settings_used = 0;
		fc_m = escp_pkg::FC_RESET;
		hand_m = 0;
		for (i = 0; i < escp_pkg::FRAMES; i++) begin
			frame_valid_m[i] = 1'b0;
			frame_page_m[i] = '0;
		end
		for (i = 0; i < escp_pkg::PAGES; i++) begin
			slot_valid_m[i] = 1'b0;
			slot_page_m[i] = '0;
			seen_m[i] = 1'b0;
			on_disk_m[i] = 1'b0;
			ref_m[i] = 1'b1;
			dirty_m[i] = 1'b0;
		end
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset frame count: first touches, hits, write marks dirty
		push_access(6'd0, 1'b0);
		push_access(6'd63, 1'b1);
		push_access(6'd0, 1'b1);
		push_access(6'd63, 1'b0);
		push_access(6'd5, 1'b0);
		// two frames: page 5 sits above the count and still hits
		set_frame_count(5'd2);
		push_access(6'd5, 1'b0);
		push_access(6'd10, 1'b1);
		push_access(6'd20, 1'b0);
		push_access(6'd0, 1'b0);
		push_access(6'd63, 1'b1);
		push_access(6'd10, 1'b0);
		push_access(6'd42, 1'b1);
		// zero acts as one frame, hand restarts at frame 0
		set_frame_count(5'd0);
		push_access(6'd7, 1'b1);
		push_access(6'd8, 1'b0);
		push_access(6'd7, 1'b0);
		push_access(6'd21, 1'b1);
		// above the frame total saturates; pages come back from disk into free frames
		set_frame_count(5'd31);
		push_access(6'd20, 1'b1);
		push_access(6'd10, 1'b0);
		push_access(6'd42, 1'b0);
		push_access(6'd8, 1'b1);
		push_access(6'd63, 1'b0);
		push_access(6'd21, 1'b0);

		for (ph = 0; ph < 10; ph++) begin
			set_frame_count(fc_plan[ph]);
			calm = (ph == 3);
			queue_random(145);
		end
		drain();
		calm = 1'b0;
		repeat (100) @(posedge clk);

		$display("%0d words checked over %0d frame_count settings", words_checked,
			settings_used);
		$display("%0d hits, %0d evictions, %0d pages read back from disk", hits_seen,
			evictions_seen, disk_ins_seen);
		if (errors == 0 && expected_words.size() == 0)
			$display("enhanced_second_chance_pager_test: done, clean");
		else
			$display("enhanced_second_chance_pager_test: done, errors");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/escp_pkg.sv
rtl/escp_ram.sv
rtl/escp_ctrl.sv
rtl/escp_dp.sv
rtl/enhanced_second_chance_pager.sv
dv/enhanced_second_chance_pager_test.sv
